>>> hdl/tmm_pkg.sv
package tmm_pkg;

  // operating modes, also the run select codes for the four treatment modules
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_RF   = 3'd1,
    MODE_SW   = 3'd2,
    MODE_PH   = 3'd3,
    MODE_US   = 3'd4,
    MODE_ERR  = 3'd5
  } mode_e;

  // probe codes as reported by the probe sense lines
  localparam logic [2:0] PROBE_NONE = 3'd0;
  localparam logic [2:0] PROBE_US   = 3'd1;
  localparam logic [2:0] PROBE_SW   = 3'd2;
  localparam logic [2:0] PROBE_RF   = 3'd3;
  localparam logic [2:0] PROBE_PH   = 3'd4;
  localparam logic [2:0] PROBE_ERR  = 3'd5;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgAddrW-1:0] CFG_FAN_ON  = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_FAN_OFF = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_DB_LIM  = 2'd2;

  // configuration reset values
  localparam logic [10:0] FAN_ON_RST  = 11'd850;
  localparam logic [10:0] FAN_OFF_RST = 11'd800;
  localparam logic [7:0]  DB_LIM_RST  = 8'd5;

  // temp = avg * 1000 / 3300 = (avg * 10) / 33, done as multiply by 2^21/33 rounded up
  localparam int unsigned TempShift = 21;
  localparam logic [15:0] TEMP_RECIP = 16'd63551;

  typedef struct packed {
    logic [2:0]  raw_probe;
    logic        foot_closed;
    logic        temp_sample;
    logic [11:0] sensor_a_mv;
    logic [11:0] sensor_b_mv;
    logic [3:0]  wait_return;
  } tmm_in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  probe_now;
    logic        fan_drive;
    logic        foot_now;
    logic [2:0]  run_select;
    logic [3:0]  reset_pulse;
    logic [10:0] pcb_temp;
  } tmm_out_t;

  // mode chosen from idle by the debounced probe
  function automatic mode_e mode_for_probe(logic [2:0] probe);
    mode_e m;
    case (probe)
      PROBE_US: m = MODE_US;
      PROBE_SW: m = MODE_SW;
      PROBE_RF: m = MODE_RF;
      PROBE_PH: m = MODE_PH;
      PROBE_ERR: m = MODE_ERR;
      default: m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/tmm_if.sv
interface tmm_in_if;
  import tmm_pkg::*;
  logic    valid;
  logic    ready;
  tmm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmm_out_if;
  import tmm_pkg::*;
  logic     valid;
  logic     ready;
  tmm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmm_cfg_if;
  import tmm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

>>> hdl/treatment_mode_manager.sv
// Treatment mode manager: takes one task tick per transfer on in_i and returns one result per
// tick on out_o. A tick can be accepted every clock cycle unless back pressure stalls it; each
// tick passes through the input register, then the result register where the probe debounce,
// fan hysteresis and mode machine state are updated together with the result. Back pressure
// on out_o stalls the input once both registers hold data. Configuration writes on cfg_i are
// always taken and must only be issued while no tick is in flight; writes to an index past
// the debounce limit are dropped.
module treatment_mode_manager (
  input  logic clk_i,
  input  logic rst_ni,
  tmm_in_if.sink    in_i,
  tmm_out_if.source out_o,
  tmm_cfg_if.sink   cfg_i
);
  import tmm_pkg::*;

  // configuration registers
  logic [10:0] fan_on_q, fan_off_q;
  logic [7:0]  db_lim_q;

  // pipeline control
  logic    s1_valid_q, out_valid_q;
  tmm_in_t s1_q;
  tmm_out_t out_q, out_d;
  logic    adv2, s2_fire, in_ready;

  // block state
  mode_e       mode_q, mode_d;
  logic [2:0]  stable_q, stable_d, pending_q, pending_d;
  logic [7:0]  count_q, count_d;
  logic        fan_q, fan_d;
  logic        foot_q;
  logic [10:0] temp_q, temp_d, temp_calc;

  logic [7:0]  count_inc;
  mode_e       mode_pre;
  logic [2:0]  run_sel;

  assign cfg_i.ready = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_on_q  <= FAN_ON_RST;
      fan_off_q <= FAN_OFF_RST;
      db_lim_q  <= DB_LIM_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_FAN_ON:  fan_on_q  <= cfg_i.wdata;
        CFG_FAN_OFF: fan_off_q <= cfg_i.wdata;
        CFG_DB_LIM:  db_lim_q  <= cfg_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  assign adv2     = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || adv2;
  assign s2_fire  = s1_valid_q && adv2;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
  end

  tmm_temp u_temp (
    .sensor_a_mv_i (s1_q.sensor_a_mv),
    .sensor_b_mv_i (s1_q.sensor_b_mv),
    .temp_o        (temp_calc)
  );

  // probe debounce
  assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

  always_comb begin
    stable_d  = stable_q;
    pending_d = pending_q;
    count_d   = count_q;
    if (s1_q.raw_probe == stable_q) begin
      count_d = '0;
    end else if (s1_q.raw_probe == pending_q) begin
      if (count_inc >= db_lim_q) begin
        stable_d  = s1_q.raw_probe;
        pending_d = s1_q.raw_probe;
        count_d   = '0;
      end else begin
        count_d = count_inc;
      end
    end else begin
      pending_d = s1_q.raw_probe;
      count_d   = 8'd1;
    end
  end

  // board temperature and fan hysteresis
  always_comb begin
    temp_d = temp_q;
    fan_d  = fan_q;
    if (s1_q.temp_sample) begin
      temp_d = temp_calc;
      if (temp_calc > fan_on_q) begin
        fan_d = 1'b1;
      end else if (temp_calc < fan_off_q) begin
        fan_d = 1'b0;
      end
    end
  end

  // mode machine, wait-return forces idle and idle is evaluated in the same tick
  always_comb begin
    mode_pre = (s1_q.wait_return != 4'd0) ? MODE_IDLE : mode_q;
    mode_d   = mode_pre;
    run_sel  = 3'd0;
    case (mode_pre)
      MODE_IDLE: mode_d = mode_for_probe(stable_d);
      MODE_RF, MODE_SW, MODE_PH, MODE_US: run_sel = mode_pre;
      default: ;
    endcase
  end

  // result
  always_comb begin
    out_d.mode        = mode_d;
    out_d.probe_now   = stable_d;
    out_d.fan_drive   = fan_d;
    out_d.foot_now    = s1_q.foot_closed;
    out_d.run_select  = run_sel;
    out_d.reset_pulse = s1_q.wait_return;
    out_d.pcb_temp    = temp_d;
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      stable_q    <= PROBE_NONE;
      pending_q   <= PROBE_NONE;
      count_q     <= '0;
      fan_q       <= 1'b0;
      foot_q      <= 1'b0;
      temp_q      <= '0;
    end else begin
      if (adv2) begin
        out_valid_q <= s1_valid_q;
      end
      if (s2_fire) begin
        mode_q    <= mode_d;
        stable_q  <= stable_d;
        pending_q <= pending_d;
        count_q   <= count_d;
        fan_q     <= fan_d;
        foot_q    <= s1_q.foot_closed;
        temp_q    <= temp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_q <= out_d;
    end
  end

  // a pending count only exists while the pending code differs from the committed one
  a_count_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 8'd0) |-> (pending_q != stable_q))
    else $error("debounce count set while pending equals stable");

  // a module sent back to init is never run in the same tick
  a_reset_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reset_pulse != 4'd0) |-> (out_q.run_select == 3'd0))
    else $error("module run in a tick with a wait-return");

  // the module that runs is the one of the current mode
  a_run_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.run_select != 3'd0) |-> (out_q.run_select == out_q.mode))
    else $error("run select disagrees with mode");

  // committed probe only moves when a tick is processed
  a_stable_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_fire |=> $stable(stable_q) && $stable(mode_q))
    else $error("state changed without a processed tick");

  // foot latch tracks the result of the last processed tick
  a_foot_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.foot_now == foot_q))
    else $error("foot output differs from latched foot state");

endmodule

>>> hdl/tmm_temp.sv
module tmm_temp (
  input  logic [11:0] sensor_a_mv_i,
  input  logic [11:0] sensor_b_mv_i,
  output logic [10:0] temp_o
);
  import tmm_pkg::*;

  logic [12:0] sum;
  logic [11:0] avg;
  logic [15:0] avg_x10;
  logic [31:0] prod;

  // average of the two sensors, truncated
  assign sum = {1'b0, sensor_a_mv_i} + {1'b0, sensor_b_mv_i};
  assign avg = sum[12:1];

  // scale by ten with shifts, then divide by 33 through the reciprocal
  assign avg_x10 = {1'b0, avg, 3'b000} + {3'b000, avg, 1'b0};
  assign prod    = {16'd0, avg_x10} * {16'd0, TEMP_RECIP};
  assign temp_o  = prod[TempShift +: 11];

endmodule

>>> bench/treatment_mode_manager_test.sv
module treatment_mode_manager_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmm_pkg::*;

  // index with no register behind it, writes there are dropped
  localparam logic [CfgAddrW-1:0] CFG_UNUSED = 2'd3;
  // run select code when no treatment module runs
  localparam logic [2:0] RUN_NONE = 3'd0;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned QuietLimit = 2000;

  logic clk;
  logic rst_n;

  tmm_in_if  in_if ();
  tmm_out_if out_if ();
  tmm_cfg_if cfg_if ();

  treatment_mode_manager i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the manager: configuration
  logic [10:0] thr_on  = FAN_ON_RST;
  logic [10:0] thr_off = FAN_OFF_RST;
  logic [7:0]  db_limit = DB_LIM_RST;

  // shadow copy of the manager: state
  mode_e       cur_mode = MODE_IDLE;
  logic [2:0]  committed_probe = PROBE_NONE;
  logic [2:0]  candidate_probe = PROBE_NONE;
  int unsigned repeat_cnt = 0;
  logic        fan_q = 1'b0;
  logic        foot_q = 1'b0;
  logic [10:0] temp_q = '0;

  tmm_out_t    results_due[$];
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  // one task tick through the shadow state, returns the result it should produce
  function automatic tmm_out_t advance_manager(input tmm_in_t t);
    tmm_out_t    r;
    logic [2:0]  run_code;
    int unsigned avg;
    run_code = RUN_NONE;
    // probe debounce
    if (t.raw_probe == committed_probe) begin
      repeat_cnt = 0;
    end else if (t.raw_probe == candidate_probe) begin
      if (repeat_cnt < 255) repeat_cnt++;
      if (repeat_cnt >= db_limit) begin
        committed_probe = t.raw_probe;
        candidate_probe = t.raw_probe;
        repeat_cnt = 0;
      end
    end else begin
      candidate_probe = t.raw_probe;
      repeat_cnt = 1;
    end
    foot_q = t.foot_closed;
    // board temperature and fan hysteresis, on is tested first
    if (t.temp_sample) begin
      avg = (32'(t.sensor_a_mv) + 32'(t.sensor_b_mv)) / 2;
      temp_q = 11'((avg * 1000) / 3300);
      if (temp_q > thr_on) fan_q = 1'b1;
      else if (temp_q < thr_off) fan_q = 1'b0;
    end
    // any wait-return drops to idle, idle is then evaluated in the same tick
    if (t.wait_return != 4'd0) cur_mode = MODE_IDLE;
    case (cur_mode)
      MODE_IDLE: begin
        case (committed_probe)
          PROBE_US:  cur_mode = MODE_US;
          PROBE_SW:  cur_mode = MODE_SW;
          PROBE_RF:  cur_mode = MODE_RF;
          PROBE_PH:  cur_mode = MODE_PH;
          PROBE_ERR: cur_mode = MODE_ERR;
          default:   cur_mode = MODE_IDLE;
        endcase
      end
      MODE_RF, MODE_SW, MODE_PH, MODE_US: begin
        run_code = cur_mode;
      end
      default: begin
      end
    endcase
    r.mode        = cur_mode;
    r.probe_now   = committed_probe;
    r.fan_drive   = fan_q;
    r.foot_now    = foot_q;
    r.run_select  = run_code;
    r.reset_pulse = t.wait_return;
    r.pcb_temp    = temp_q;
    return r;
  endfunction

  function automatic tmm_in_t make_tick(input logic [2:0] raw, input logic foot,
                                        input logic samp, input logic [11:0] va,
                                        input logic [11:0] vb, input logic [3:0] wr);
    tmm_in_t t;
    t.raw_probe   = raw;
    t.foot_closed = foot;
    t.temp_sample = samp;
    t.sensor_a_mv = va;
    t.sensor_b_mv = vb;
    t.wait_return = wr;
    return t;
  endfunction

  // one tick transfer, with an optional idle burst ahead of it
  task automatic send_tick(input tmm_in_t t);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    results_due.push_back(advance_manager(t));
    ticks_sent++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_FAN_ON:  thr_on = val;
      CFG_FAN_OFF: thr_off = val;
      CFG_DB_LIM:  db_limit = val[7:0];
      default: begin
      end
    endcase
    cfg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [10:0] on_val, input logic [10:0] off_val,
                            input logic [10:0] lim_val);
    wait_drained();
    write_reg(CFG_FAN_ON, on_val);
    write_reg(CFG_FAN_OFF, off_val);
    write_reg(CFG_DB_LIM, lim_val);
  endtask

  // probe codes held in runs long enough to commit, with optional glitches,
  // sparse wait-returns and temperatures near a fan threshold on about half the ticks
  task automatic drive_probe_runs(input int n, input int noise_odds);
    tmm_in_t    t;
    logic [2:0] held;
    int         left;
    int         v;
    left = 0;
    held = PROBE_NONE;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        held = 3'($urandom_range(0, 7));
        left = int'(db_limit) + $urandom_range(2, 8);
      end
      left--;
      t.raw_probe = held;
      if (noise_odds != 0 && $urandom_range(0, noise_odds - 1) == 0)
        t.raw_probe = 3'($urandom_range(0, 7));
      t.foot_closed = 1'($urandom);
      t.temp_sample = 1'($urandom);
      t.wait_return = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
      if ($urandom_range(0, 1) == 0) begin
        v = int'($urandom_range(0, 1) ? thr_on : thr_off) * 33 / 10
            + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        t.sensor_a_mv = 12'(v);
        t.sensor_b_mv = 12'(v);
      end else begin
        t.sensor_a_mv = 12'($urandom);
        t.sensor_b_mv = 12'($urandom);
      end
      send_tick(t);
    end
  endtask

  // reset thresholds and debounce limit: fan edges, temperature extremes, slow commit
  task automatic test_fan_hysteresis();
    send_tick(make_tick(PROBE_SW, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b1, 1'b1, 12'd2706, 12'd2706, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b0, 1'b1, 12'd2805, 12'd2805, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b1, 1'b1, 12'd2838, 12'd2838, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b0, 1'b1, 12'd2640, 12'd2640, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b1, 1'b1, 12'd4095, 12'd4094, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b0, 1'b1, 12'd2607, 12'd2607, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b0, 1'b1, 12'd1, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_SW, 1'b1, 1'b0, 12'd4095, 12'd4095, 4'd0));
  endtask

  // debounce limit zero, then every mode, same-tick reentry and unknown probes
  task automatic test_mode_walk();
    set_config(FAN_ON_RST, FAN_OFF_RST, 11'd0);
    send_tick(make_tick(PROBE_RF, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_RF, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_RF, 1'b0, 1'b0, 12'd0, 12'd0, 4'b0001));
    send_tick(make_tick(PROBE_RF, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_ERR, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_ERR, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_ERR, 1'b0, 1'b0, 12'd0, 12'd0, 4'b0010));
    send_tick(make_tick(PROBE_US, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_US, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_US, 1'b0, 1'b0, 12'd0, 12'd0, 4'b1111));
    send_tick(make_tick(PROBE_PH, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_PH, 1'b1, 1'b0, 12'd0, 12'd0, 4'b0100));
    send_tick(make_tick(3'd6, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(3'd6, 1'b0, 1'b0, 12'd0, 12'd0, 4'b1000));
    send_tick(make_tick(3'd7, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(3'd7, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_NONE, 1'b1, 1'b0, 12'd0, 12'd0, 4'd0));
    send_tick(make_tick(PROBE_NONE, 1'b0, 1'b0, 12'd0, 12'd0, 4'd0));
  endtask

  // largest debounce limit, codes held clean long enough to commit
  task automatic test_slow_debounce();
    set_config(FAN_ON_RST, FAN_OFF_RST, 11'd255);
    drive_probe_runs(270, 0);
  endtask

  // crossed and extreme thresholds, a masked limit and a dropped register write
  task automatic test_threshold_sweep();
    set_config(11'd0, 11'd1240, 11'd1);
    drive_probe_runs(80, 12);
    set_config(11'd1240, 11'd0, 11'd3);
    drive_probe_runs(80, 12);
    set_config(11'd2047, 11'd2047, 11'h102);
    write_reg(CFG_UNUSED, 11'h7FF);
    drive_probe_runs(80, 12);
    set_config(FAN_ON_RST, FAN_OFF_RST, 11'(DB_LIM_RST));
    drive_probe_runs(80, 8);
  endtask

  // back to back traffic, no idling on either side
  task automatic test_quiet_finish();
    set_config(11'd600, 11'd400, 11'd2);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    drive_probe_runs(60, 12);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result sink, ready drops in random bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    tmm_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_if.data);
        errors++;
      end else begin
        want = results_due.pop_front();
        compare_field("mode", want.mode, out_if.data.mode);
        compare_field("probe_now", want.probe_now, out_if.data.probe_now);
        compare_field("fan_drive", want.fan_drive, out_if.data.fan_drive);
        compare_field("foot_now", want.foot_now, out_if.data.foot_now);
        compare_field("run_select", want.run_select, out_if.data.run_select);
        compare_field("reset_pulse", want.reset_pulse, out_if.data.reset_pulse);
        compare_field("pcb_temp", want.pcb_temp, out_if.data.pcb_temp);
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, results_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.addr  <= '0;
    cfg_if.wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fan_hysteresis();
    test_mode_walk();
    test_slow_debounce();
    test_threshold_sweep();
    test_quiet_finish();

    // drain and let the pipeline settle
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d ticks, %0d results, %0d register writes", ticks_sent,
             results_checked, cfg_writes);
    $display("fan edges, all modes and probe codes, wait-return reentry, crossed thresholds");
    if (errors == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tmm_pkg.sv
hdl/tmm_if.sv
hdl/tmm_temp.sv
hdl/treatment_mode_manager.sv
bench/treatment_mode_manager_test.sv
